// File: src/rdsm_pkg.sv
// Package with the shared types and constants of the dot-star regex matcher.
package rdsm_pkg;

  localparam int PATTERN_MAX_DEF = 32;
  localparam int PAT_BYTES       = 32;
  localparam int LEN_W           = 6;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 64;
  localparam int WORD_BYTES      = 8;

  localparam logic [7:0] STAR_CHAR = 8'h2A;
  localparam logic [7:0] DOT_CHAR  = 8'h2E;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LENGTH = 3'd0,
    CFG_LOW    = 3'd1,
    CFG_SECOND = 3'd2,
    CFG_THIRD  = 3'd3,
    CFG_HIGH   = 3'd4
  } cfg_idx_t;

  typedef logic [PAT_BYTES-1:0][7:0] pat_arr_t;

  typedef struct packed {
    logic       valid;
    logic       mode;
    logic [7:0] text;
    logic       cur;
    logic       cur_m1;
    logic       old;
    logic       res;
  } pkt_t;

endpackage

// File: src/rdsm_cfg_regs.sv
// Configuration registers: pattern length and the four pattern words.
module rdsm_cfg_regs #(
  parameter int PATTERN_MAX = rdsm_pkg::PATTERN_MAX_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [rdsm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rdsm_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output rdsm_pkg::pat_arr_t               pat,
  output logic [rdsm_pkg::LEN_W-1:0]       used_len
);
  import rdsm_pkg::*;

  logic [LEN_W-1:0]      len_r;
  logic [CFG_DATA_W-1:0] word_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r     <= '0;
      word_r[0] <= '0;
      word_r[1] <= '0;
      word_r[2] <= '0;
      word_r[3] <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LENGTH: len_r     <= cfg_wdata[LEN_W-1:0];
        CFG_LOW:    word_r[0] <= cfg_wdata;
        CFG_SECOND: word_r[1] <= cfg_wdata;
        CFG_THIRD:  word_r[2] <= cfg_wdata;
        CFG_HIGH:   word_r[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int b = 0; b < PAT_BYTES; b++) begin
      pat[b] = word_r[b / WORD_BYTES][(b % WORD_BYTES) * 8 +: 8];
    end
  end

  assign used_len = (len_r > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX) : len_r;

endmodule

// File: src/rdsm_cell.sv
// One pattern column: holds one bit of the match row and passes the beat on.
module rdsm_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           adv,
  input  logic [7:0]     pat_cur,
  input  logic [7:0]     pat_prev,
  input  logic           has_pred,
  input  logic           tap,
  input  rdsm_pkg::pkt_t pkt_i,
  output rdsm_pkg::pkt_t pkt_o
);
  import rdsm_pkg::*;

  logic row_r;
  logic row_nxt;
  pkt_t pkt_r;
  pkt_t pkt_nxt;
  logic v;

  always_comb begin
    v = 1'b0;
    if (!pkt_i.mode) begin
      if (pat_cur == STAR_CHAR && has_pred) begin
        v = pkt_i.cur_m1;
      end
    end else if (pat_cur == STAR_CHAR) begin
      if (has_pred) begin
        if (pat_prev == pkt_i.text || pat_prev == DOT_CHAR) begin
          v = pkt_i.cur_m1 | pkt_i.cur | row_r;
        end else begin
          v = pkt_i.cur_m1;
        end
      end
    end else if (pat_cur == pkt_i.text || pat_cur == DOT_CHAR) begin
      v = pkt_i.old;
    end
  end

  always_comb begin
    pkt_nxt        = pkt_i;
    pkt_nxt.cur    = v;
    pkt_nxt.cur_m1 = pkt_i.cur;
    pkt_nxt.old    = row_r;
    pkt_nxt.res    = tap ? v : pkt_i.res;
    row_nxt        = pkt_i.valid ? v : row_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r       <= 1'b0;
      pkt_r.valid <= 1'b0;
    end else if (adv) begin
      row_r <= row_nxt;
      pkt_r <= pkt_nxt;
    end
  end

  assign pkt_o = pkt_r;

endmodule

// File: src/regex_dot_star_matcher_unit.sv
// Top level of the dot-star regex matcher: configuration, head stage and cell chain.
//
// Usage: load the pattern through the cfg_ port while the block is idle
// (index 0 length, indices 1 to 4 the pattern words, lowest byte first).
// Each input beat carries in_tuser (0 starts a new empty text, 1 appends
// the byte in in_tdata). Every input beat yields exactly one output beat
// whose out_tdata bit 0 tells whether the text since the last start
// matches the whole pattern.
// A beat travels down a chain of PATTERN_MAX cells, one pattern column per
// cell, and is registered in each cell in turn until the last cell offers
// it on the output; the chain accepts one beat per cycle while the receiver
// takes them.
// When the receiver stalls with a result waiting in the last cell, the
// whole chain holds and in_tready drops until that beat is taken.
// Reset clears the match row, the configuration and all valid flags.
module regex_dot_star_matcher_unit #(
  parameter int PATTERN_MAX = rdsm_pkg::PATTERN_MAX_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [7:0]                       in_tdata,   // [7:0] text_byte
  input  logic                             in_tuser,   // [0] mode
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [7:0]                       out_tdata,  // [0] matched, [7:1] zero
  input  logic                             cfg_we,
  input  logic [rdsm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rdsm_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import rdsm_pkg::*;

  pat_arr_t         pat;
  logic [LEN_W-1:0] used_len;
  logic             adv;
  logic             row0_r;
  pkt_t             chain [PATTERN_MAX+1];

  rdsm_cfg_regs #(.PATTERN_MAX(PATTERN_MAX)) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .pat      (pat),
    .used_len (used_len)
  );

  assign adv       = !chain[PATTERN_MAX].valid || out_tready;
  assign in_tready = adv;

  always_comb begin
    chain[0].valid  = in_tvalid && adv;
    chain[0].mode   = in_tuser;
    chain[0].text   = in_tdata;
    chain[0].cur    = !in_tuser;
    chain[0].cur_m1 = 1'b0;
    chain[0].old    = row0_r;
    chain[0].res    = (used_len == '0) ? !in_tuser : 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row0_r <= 1'b0;
    end else if (in_tvalid && adv) begin
      row0_r <= !in_tuser;
    end
  end

  for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_cell
    logic [7:0] prev_b;
    logic       tap;

    assign prev_b = (j == 0) ? 8'h00 : pat[(j == 0) ? 0 : j - 1];
    assign tap    = (used_len == LEN_W'(j + 1));

    rdsm_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .pat_cur (pat[j]),
      .pat_prev(prev_b),
      .has_pred(1'(j != 0)),
      .tap     (tap),
      .pkt_i   (chain[j]),
      .pkt_o   (chain[j+1])
    );
  end

  assign out_tvalid = chain[PATTERN_MAX].valid;
  assign out_tdata  = {7'b0, chain[PATTERN_MAX].res};

endmodule

// File: src/rdsm_checker.sv
// Port-level checks of the dot-star regex matcher, bound to the top level.
module rdsm_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata
);

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("Output beat offered right after reset.");

  a_ready_follows_output: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("Input ready does not follow the output stage.");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("Stalled output beat changed.");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[7:1] == 7'b0)
    else $error("Output padding bits are not zero.");

endmodule

bind regex_dot_star_matcher_unit rdsm_checker u_rdsm_checker (.*);

// File: verif/regex_dot_star_matcher_unit_tb.sv
// Self-checking testbench for the dot-star regex matcher with a built-in match-row predictor.
`timescale 1ns / 100ps

module regex_dot_star_matcher_unit_tb;
  import rdsm_pkg::*;

  localparam int PIPE_DEPTH   = PATTERN_MAX_DEF;
  localparam int RANDOM_BEATS = 1550;

  class match_checker;
    bit [CFG_DATA_W-1:0]    pat_words[4];
    bit [LEN_W-1:0]         pat_len;
    bit [PATTERN_MAX_DEF:0] row;
    bit                     want_matched[$];
    int                     errors;
    int                     results;
    int                     match_count;

    function bit [7:0] pat_char(int j);
      return pat_words[j / WORD_BYTES][(j % WORD_BYTES) * 8 +: 8];
    endfunction

    function void set_reg(cfg_idx_t idx, bit [CFG_DATA_W-1:0] v);
      case (idx)
        CFG_LENGTH: pat_len = v[LEN_W-1:0];
        CFG_LOW:    pat_words[0] = v;
        CFG_SECOND: pat_words[1] = v;
        CFG_THIRD:  pat_words[2] = v;
        CFG_HIGH:   pat_words[3] = v;
        default: ;
      endcase
    endfunction

    function void note_beat(bit mode, bit [7:0] c);
      bit [PATTERN_MAX_DEF:0] nxt;
      bit [7:0]               p;
      bit [7:0]               q;
      bit                     v;
      int                     used;
      nxt = '0;
      if (!mode) begin
        nxt[0] = 1'b1;
        for (int j = 0; j < PATTERN_MAX_DEF; j++) begin
          if (pat_char(j) == STAR_CHAR && j >= 1) nxt[j+1] = nxt[j-1];
        end
      end else begin
        for (int j = 0; j < PATTERN_MAX_DEF; j++) begin
          p = pat_char(j);
          v = 1'b0;
          if (p == STAR_CHAR) begin
            if (j > 0) begin
              q = pat_char(j - 1);
              if (q == c || q == DOT_CHAR) v = nxt[j-1] | nxt[j] | row[j+1];
              else v = nxt[j-1];
            end
          end else if (p == c || p == DOT_CHAR) begin
            v = row[j];
          end
          nxt[j+1] = v;
        end
      end
      row = nxt;
      used = (pat_len > PATTERN_MAX_DEF) ? PATTERN_MAX_DEF : int'(pat_len);
      want_matched.push_back(row[used]);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 20) $display("ERROR at %0t: %s", $time, msg);
    endtask

    task check_beat(logic [7:0] d);
      bit exp_bit;
      if (want_matched.size() == 0) begin
        report($sformatf("result beat 0x%02h with nothing outstanding", d));
        return;
      end
      exp_bit = want_matched.pop_front();
      results++;
      if (d[0] !== exp_bit)
        report($sformatf("matched is %b, expected %b (result %0d)", d[0], exp_bit, results));
      if (d[7:1] !== 7'd0)
        report($sformatf("padding bits of result %0d are 0x%02h", results, d[7:1]));
      if (d[0] === 1'b1) match_count++;
    endtask
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [7:0]            in_tdata;   // [7:0] text_byte
  logic                  in_tuser;   // [0] mode
  logic                  out_tvalid;
  logic                  out_tready;
  logic [7:0]            out_tdata;  // [0] matched, [7:1] zero
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  match_checker chk;
  bit           steady;
  int           sent;
  int           starts;
  int           reg_writes;
  bit [7:0]     pat[PATTERN_MAX_DEF];
  bit [7:0]     txt[$];

  regex_dot_star_matcher_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_tready <= steady || ($urandom_range(99) >= 35);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) chk.check_beat(out_tdata);
  end

  initial begin
    #4_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  task send_beat(bit mode, bit [7:0] b);
    while (!steady && $urandom_range(99) < 35) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 8'($urandom);
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= b;
    do @(posedge clk); while (in_tready !== 1'b1);
    chk.note_beat(mode, b);
    sent++;
    if (!mode) starts++;
    @(negedge clk);
  endtask

  task write_reg(cfg_idx_t idx, bit [CFG_DATA_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    chk.set_reg(idx, v);
    reg_writes++;
    @(negedge clk);
    cfg_we    <= 1'b0;
    cfg_wdata <= {$urandom, $urandom};
    @(negedge clk);
  endtask

  task settle();
    in_tvalid <= 1'b0;
    while (chk.want_matched.size() != 0) @(negedge clk);
    repeat (PIPE_DEPTH) @(negedge clk);
  endtask

  function bit [7:0] pick_byte();
    int r;
    r = $urandom_range(9);
    if (r < 4) return 8'h61;
    if (r < 6) return 8'h62;
    if (r < 7) return 8'h63;
    if (r < 8) return STAR_CHAR;
    if (r < 9) return DOT_CHAR;
    return 8'($urandom);
  endfunction

  task make_pattern();
    int j;
    int r;
    j = 0;
    while (j < PATTERN_MAX_DEF) begin
      r = $urandom_range(99);
      if (r < 60) pat[j] = 8'h61 + 8'($urandom_range(2));
      else if (r < 80) pat[j] = DOT_CHAR;
      else if (r < 90) pat[j] = 8'($urandom);
      else pat[j] = STAR_CHAR;
      j++;
      if (j < PATTERN_MAX_DEF && $urandom_range(99) < 35) begin
        pat[j] = STAR_CHAR;
        j++;
      end
    end
  endtask

  task write_pattern();
    bit [CFG_DATA_W-1:0] word;
    for (int w = 0; w < 4; w++) begin
      for (int k = 0; k < WORD_BYTES; k++) word[k*8 +: 8] = pat[w*WORD_BYTES + k];
      write_reg(cfg_idx_t'(int'(CFG_LOW) + w), word);
    end
  endtask

  // Builds a text that follows the pattern element by element, then sometimes damages it.
  task make_text();
    int used;
    int j;
    int n;
    bit [7:0] ch;
    txt.delete();
    used = (chk.pat_len > PATTERN_MAX_DEF) ? PATTERN_MAX_DEF : int'(chk.pat_len);
    j = 0;
    while (j < used) begin
      ch = pat[j];
      if (j + 1 < used && pat[j+1] == STAR_CHAR && ch != STAR_CHAR) begin
        n = $urandom_range(3);
        repeat (n) txt.push_back(ch == DOT_CHAR ? pick_byte() : ch);
        j += 2;
      end else begin
        if (ch != STAR_CHAR) txt.push_back(ch == DOT_CHAR ? pick_byte() : ch);
        j++;
      end
    end
    if ($urandom_range(99) < 30) begin
      case ($urandom_range(2))
        0: if (txt.size() > 0) txt[$urandom_range(txt.size() - 1)] = 8'($urandom);
        1: txt.push_back(pick_byte());
        default: if (txt.size() > 0) txt.delete($urandom_range(txt.size() - 1));
      endcase
    end
  endtask

  initial begin
    bit [CFG_DATA_W-1:0] v;
    int base;
    int r;
    chk        = new();
    steady     = 1'b0;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = 8'h00;
    in_tuser   = 1'b0;
    out_tready = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = CFG_LENGTH;
    cfg_wdata  = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // A byte before any start, then the empty pattern.
    send_beat(1'b1, 8'h00);
    send_beat(1'b0, 8'h00);
    send_beat(1'b1, 8'hFF);
    settle();
    // Leading star, which can never match.
    write_reg(CFG_LOW, 64'h2A2E612A);
    write_reg(CFG_LENGTH, 64'd4);
    send_beat(1'b0, 8'hFF);
    send_beat(1'b1, 8'h61);
    send_beat(1'b1, 8'h00);
    send_beat(1'b1, STAR_CHAR);
    settle();
    // A star in the text meets a star operator.
    write_reg(CFG_LOW, 64'h2A61);
    write_reg(CFG_LENGTH, 64'd2);
    send_beat(1'b0, 8'h00);
    send_beat(1'b1, STAR_CHAR);
    send_beat(1'b1, 8'h61);
    send_beat(1'b1, 8'h61);
    settle();
    // Length beyond the maximum over a full row of dot-star pairs.
    for (int w = 0; w < 4; w++) write_reg(cfg_idx_t'(int'(CFG_LOW) + w), {4{16'h2A2E}});
    write_reg(CFG_LENGTH, {CFG_DATA_W{1'b1}});
    send_beat(1'b0, 8'hFF);
    send_beat(1'b1, 8'hFF);
    send_beat(1'b1, 8'h00);
    settle();
    for (int w = 0; w < 4; w++) write_reg(cfg_idx_t'(int'(CFG_LOW) + w), {CFG_DATA_W{1'b1}});
    write_reg(CFG_LENGTH, 64'd32);
    send_beat(1'b0, 8'h00);
    repeat (3) send_beat(1'b1, 8'hFF);
    settle();
    write_reg(CFG_LENGTH, 64'd0);
    send_beat(1'b0, 8'hFF);
    send_beat(1'b1, 8'hFF);

    base = sent;
    while (sent - base < RANDOM_BEATS) begin
      settle();
      steady = (sent - base >= 600) && (sent - base < 900);
      r = $urandom_range(99);
      if (r < 85) begin
        v = {$urandom, $urandom};
        r = $urandom_range(99);
        if (r < 8) v[LEN_W-1:0] = 6'd0;
        else if (r < 16) v[LEN_W-1:0] = 6'd32;
        else if (r < 22) v[LEN_W-1:0] = 6'($urandom_range(33, 63));
        else if (r < 55) v[LEN_W-1:0] = 6'($urandom_range(1, 32));
        else v[LEN_W-1:0] = 6'($urandom_range(1, 8));
        if ($urandom_range(99) < 80) begin
          make_pattern();
          write_pattern();
        end
        write_reg(CFG_LENGTH, v);
      end
      repeat ($urandom_range(1, 4)) begin
        if ($urandom_range(99) < 90) send_beat(1'b0, 8'($urandom));
        make_text();
        foreach (txt[i]) send_beat(1'b1, txt[i]);
        if ($urandom_range(99) < 15) begin
          repeat ($urandom_range(1, 4)) send_beat(1'($urandom_range(1)), 8'($urandom));
        end
      end
    end

    steady = 1'b0;
    settle();
    $display("Sent %0d input beats, %0d of them text starts, with %0d register writes.",
             sent, starts, reg_writes);
    $display("Checked %0d result beats, %0d of them reporting a match.",
             chk.results, chk.match_count);
    if (chk.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
src/rdsm_pkg.sv
src/rdsm_cfg_regs.sv
src/rdsm_cell.sv
src/regex_dot_star_matcher_unit.sv
src/rdsm_checker.sv
verif/regex_dot_star_matcher_unit_tb.sv
